/* sv/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and controller/datapath interface types for the
// fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 16;
    localparam int CNT_W       = 9;
    localparam int STAT_W      = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUOT_W      = 9;
    localparam int MUL_B_W     = 16;

    localparam int MAX_BLOCKS_DEF = 256;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO      = 3'd1;
    localparam logic [STAT_W-1:0] ST_LARGE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_OWNED = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE_USED = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 2'd2;

    localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd4096;
    localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE  = 16'd16;
    localparam logic [CNT_W-1:0]  RST_NUM_BLOCKS  = 9'd256;

    typedef struct packed {
        logic              capture;
        logic              mem_rd;
        logic              mul_lim;
        logic              div_start;
        logic              div_step;
        logic              pop;
        logic              push;
        logic              rebuild;
        logic              load_res;
        logic [STAT_W-1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              req_zero;
        logic              req_large;
        logic              exhausted;
        logic              addr_null;
        logic              in_range;
        logic              owned;
        logic              used_zero;
        logic              idx_ok;
        logic              div_last;
    } t_dp_sts;

endpackage

/* sv/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer for allocate, free and rebuild items; drives the datapath and
// the result strobe.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  fbpa_pkg::t_dp_sts i_sts,
    output fbpa_pkg::t_dp_cmd o_cmd,
    output logic              o_res_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_DIV,
        S_CHECK
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;

    always_comb begin
        n_state     = r_state;
        n_res_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.mode)
                    fbpa_pkg::MODE_ALLOC: begin
                        if (i_sts.req_zero) begin
                            o_cmd.load_res   = 1'b1;
                            o_cmd.res_status = fbpa_pkg::ST_ZERO;
                        end else if (i_sts.req_large) begin
                            o_cmd.load_res   = 1'b1;
                            o_cmd.res_status = fbpa_pkg::ST_LARGE;
                        end else if (i_sts.exhausted) begin
                            o_cmd.load_res   = 1'b1;
                            o_cmd.res_status = fbpa_pkg::ST_EXHAUSTED;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                        end
                    end
                    fbpa_pkg::MODE_FREE: begin
                        if (i_sts.addr_null) begin
                            o_cmd.load_res   = 1'b1;
                            o_cmd.res_status = fbpa_pkg::ST_OK;
                        end else if (!i_sts.in_range) begin
                            o_cmd.load_res   = 1'b1;
                            o_cmd.res_status = fbpa_pkg::ST_NOT_OWNED;
                        end else begin
                            o_cmd.mul_lim   = 1'b1;
                            o_cmd.div_start = 1'b1;
                        end
                    end
                    fbpa_pkg::MODE_REBUILD: begin
                        o_cmd.rebuild    = 1'b1;
                        o_cmd.load_res   = 1'b1;
                        o_cmd.res_status = fbpa_pkg::ST_OK;
                    end
                    default: begin
                        o_cmd.load_res   = 1'b1;
                        o_cmd.res_status = fbpa_pkg::ST_OK;
                    end
                endcase
                if (o_cmd.load_res) begin
                    n_state = S_IDLE;
                end else if (o_cmd.mem_rd) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_ALLOC: begin
                o_cmd.pop        = 1'b1;
                o_cmd.load_res   = 1'b1;
                o_cmd.res_status = fbpa_pkg::ST_OK;
                n_state          = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.load_res = 1'b1;
                if (!i_sts.owned) begin
                    o_cmd.res_status = fbpa_pkg::ST_NOT_OWNED;
                end else if (i_sts.used_zero) begin
                    o_cmd.res_status = fbpa_pkg::ST_NONE_USED;
                end else if (!i_sts.idx_ok) begin
                    o_cmd.res_status = fbpa_pkg::ST_NOT_OWNED;
                end else begin
                    o_cmd.push       = 1'b1;
                    o_cmd.res_status = fbpa_pkg::ST_OK;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_res_valid = o_cmd.load_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;

endmodule

/* sv/fbpa_dpath.sv */
// ----------------------------------------------------------------------------
// fbpa_dpath
// Config registers, free-list link store, head and used count, shared
// multiplier, restoring divider and result registers.
// ----------------------------------------------------------------------------
module fbpa_dpath #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [fbpa_pkg::MODE_W-1:0]      i_mode,
    input  logic [fbpa_pkg::ADDR_W-1:0]      i_request_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]      i_free_address,
    input  fbpa_pkg::t_dp_cmd                i_cmd,
    output fbpa_pkg::t_dp_sts                o_sts,
    output logic [fbpa_pkg::STAT_W-1:0]      o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]      o_block_address,
    output logic [fbpa_pkg::CNT_W-1:0]       o_used_blocks,
    output logic [fbpa_pkg::CNT_W-1:0]       o_free_blocks
);

    localparam int IW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW     = $clog2(MAX_BLOCKS + 1);
    localparam int DCNT_W = $clog2(fbpa_pkg::QUOT_W);

    // configuration
    logic [fbpa_pkg::ADDR_W-1:0] r_pool_base;
    logic [fbpa_pkg::SIZE_W-1:0] r_block_size;
    logic [fbpa_pkg::CNT_W-1:0]  r_num_blocks;

    // captured item
    logic [fbpa_pkg::MODE_W-1:0] r_mode;
    logic [fbpa_pkg::ADDR_W-1:0] r_req;
    logic [fbpa_pkg::ADDR_W-1:0] r_addr;

    // list state
    logic [LW-1:0]              r_head;
    logic [fbpa_pkg::CNT_W-1:0] r_used, n_used;
    logic [LW-1:0]              mem_link [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]      r_link_vld;

    logic [IW-1:0] r_rd_idx;
    logic [LW-1:0] r_rd_link;
    logic          r_rd_vld;
    logic [LW-1:0] pop_link;

    // multiplier and divider
    logic [fbpa_pkg::MUL_B_W-1:0] mul_b;
    logic [fbpa_pkg::ADDR_W-1:0]  r_prod;
    logic [fbpa_pkg::ADDR_W-1:0]  r_rem;
    logic [fbpa_pkg::ADDR_W-1:0]  r_dvs;
    logic [fbpa_pkg::QUOT_W-1:0]  r_quot;
    logic [DCNT_W-1:0]            r_dcnt;
    logic                         rem_ge;

    logic [fbpa_pkg::CNT_W-1:0]  eff_cnt;
    logic [fbpa_pkg::ADDR_W-1:0] offset;
    logic [IW-1:0]               head_idx;
    logic [31:0]                 quot_ext;
    logic [IW-1:0]               push_idx;

    logic [fbpa_pkg::STAT_W-1:0] r_status;
    logic [fbpa_pkg::ADDR_W-1:0] r_baddr;
    logic [fbpa_pkg::CNT_W-1:0]  r_used_out;
    logic [fbpa_pkg::CNT_W-1:0]  r_free_out;

    // a block total above the built capacity acts as the capacity
    assign eff_cnt  = (32'(r_num_blocks) > 32'(MAX_BLOCKS)) ?
                      fbpa_pkg::CNT_W'(MAX_BLOCKS) : r_num_blocks;
    assign offset   = r_addr - r_pool_base;
    assign head_idx = r_head[IW-1:0];
    assign quot_ext = 32'(r_quot);
    assign push_idx = quot_ext[IW-1:0];
    assign mul_b    = i_cmd.mem_rd ? fbpa_pkg::MUL_B_W'(head_idx) :
                                     fbpa_pkg::MUL_B_W'(eff_cnt);
    assign rem_ge   = (r_rem >= r_dvs);
    // an entry not written since the last rebuild links to the next block
    assign pop_link = r_rd_vld ? r_rd_link : (LW'(r_rd_idx) + LW'(1));

    always_comb begin
        n_used = r_used;
        if (i_cmd.rebuild) begin
            n_used = '0;
        end else if (i_cmd.pop) begin
            n_used = r_used + fbpa_pkg::CNT_W'(1);
        end else if (i_cmd.push) begin
            n_used = r_used - fbpa_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.req_zero  = (r_req == '0);
        o_sts.req_large = (r_req > 32'(r_block_size));
        o_sts.exhausted = (r_used >= eff_cnt) || (32'(r_head) >= 32'(MAX_BLOCKS));
        o_sts.addr_null = (r_addr == '0);
        o_sts.in_range  = (r_block_size != '0) && (r_addr >= r_pool_base);
        o_sts.owned     = (offset < r_prod) && (r_rem == '0);
        o_sts.used_zero = (r_used == '0);
        o_sts.idx_ok    = (quot_ext < 32'(MAX_BLOCKS));
        o_sts.div_last  = (r_dcnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= fbpa_pkg::RST_POOL_BASE;
            r_block_size  <= fbpa_pkg::RST_BLOCK_SIZE;
            r_num_blocks  <= fbpa_pkg::RST_NUM_BLOCKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_POOL_BASE:   r_pool_base   <= i_cfg_data;
                fbpa_pkg::CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_NUM_BLOCKS:  r_num_blocks  <= i_cfg_data[fbpa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_used     <= '0;
            r_link_vld <= '0;
        end else begin
            r_used <= n_used;
            if (i_cmd.rebuild) begin
                r_head     <= '0;
                r_link_vld <= '0;
            end else if (i_cmd.pop) begin
                r_head <= pop_link;
            end else if (i_cmd.push) begin
                r_head               <= LW'(r_quot);
                r_link_vld[push_idx] <= 1'b1;
            end
        end
    end

    // link store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_link[push_idx] <= r_head;
        end
        if (i_cmd.mem_rd) begin
            r_rd_idx  <= head_idx;
            r_rd_link <= mem_link[head_idx];
            r_rd_vld  <= r_link_vld[head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_req  <= i_request_size;
            r_addr <= i_free_address;
        end
        if (i_cmd.mem_rd || i_cmd.mul_lim) begin
            r_prod <= 32'(r_block_size) * 32'(mul_b);
        end
        // restoring division, one quotient bit a cycle, MSB first
        if (i_cmd.div_start) begin
            r_rem  <= offset;
            r_dvs  <= 32'(r_block_size) << (fbpa_pkg::QUOT_W - 1);
            r_quot <= '0;
            r_dcnt <= DCNT_W'(fbpa_pkg::QUOT_W - 1);
        end else if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs  <= r_dvs >> 1;
            r_quot <= {r_quot[fbpa_pkg::QUOT_W-2:0], rem_ge};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
        if (i_cmd.load_res) begin
            r_status   <= i_cmd.res_status;
            r_baddr    <= i_cmd.pop ? (r_pool_base + r_prod) : '0;
            r_used_out <= n_used;
            r_free_out <= (eff_cnt > n_used) ? (eff_cnt - n_used) : '0;
        end
    end

    assign o_status        = r_status;
    assign o_block_address = r_baddr;
    assign o_used_blocks   = r_used_out;
    assign o_free_blocks   = r_free_out;

endmodule

/* sv/fixed_block_pool_allocator_core.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator with a LIFO free list of block indices.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -------------------------------------------
//   item in   start / busy            i_mode, i_request_size, i_free_address
//   result    o_result_valid strobe   o_status, o_block_address,
//                                     o_used_blocks, o_free_blocks
//   config    i_cfg_we                i_cfg_index, i_cfg_data
//
// Allocate: link store read, then pop and address add.
// Refused allocate, null or out-of-range free, rebuild: settled in the decode state.
// Free in range: runs the 9-step restoring divider, then the ownership check.
// The result strobe is high one cycle and cannot be held off; busy is low then.
// Synchronous reset rebuilds the list at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fbpa_pkg::MODE_W-1:0]     i_mode,
    input  logic [fbpa_pkg::ADDR_W-1:0]     i_request_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]     i_free_address,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic [fbpa_pkg::STAT_W-1:0]     o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]     o_block_address,
    output logic [fbpa_pkg::CNT_W-1:0]      o_used_blocks,
    output logic [fbpa_pkg::CNT_W-1:0]      o_free_blocks
);

    fbpa_pkg::t_dp_cmd dp_cmd;
    fbpa_pkg::t_dp_sts dp_sts;

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_res_valid (o_result_valid)
    );

    fbpa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_request_size  (i_request_size),
        .i_free_address  (i_free_address),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_used_blocks   (o_used_blocks),
        .o_free_blocks   (o_free_blocks)
    );

endmodule

/* sv/fbpa_checker.sv */
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks on the allocator's item and result sequencing.
// ----------------------------------------------------------------------------
module fbpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic [fbpa_pkg::STAT_W-1:0] o_status,
    input logic [fbpa_pkg::ADDR_W-1:0] o_block_address,
    input logic [fbpa_pkg::CNT_W-1:0]  o_used_blocks
);

    // an accepted beat keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("results in consecutive cycles");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_block_address != '0)) |-> (o_status == fbpa_pkg::ST_OK))
        else $error("block address given with failing status");

    a_none_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == fbpa_pkg::ST_NONE_USED)) |-> (o_used_blocks == '0))
        else $error("none-in-use status with blocks in use");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_valid  (o_result_valid),
    .o_status        (o_status),
    .o_block_address (o_block_address),
    .o_used_blocks   (o_used_blocks)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed block pool allocator core. A table of
// directed ops covers refusals, ownership failures, exhaustion, clamped and
// empty pools, zero block size and address wrap. Random phases follow under
// several register settings. Every result beat is checked against a pinned
// table value or an in-bench free-list model.
// ----------------------------------------------------------------------------
module tb_top;

    import fbpa_pkg::*;

    localparam int MAX_SLOTS       = MAX_BLOCKS_DEF;
    localparam int N_PHASES        = 8;
    localparam int N_PHASE_OPS     = 140;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 16;

    // op code 3 is not decoded by the block
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  avail;
    } pool_result_t;

    typedef enum logic {ROW_OP, ROW_REG} row_kind_e;

    // for ROW_REG rows, word carries the register data
    typedef struct packed {
        row_kind_e            kind;
        logic [MODE_W-1:0]    mode;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    word;
        logic [ADDR_W-1:0]    faddr;
        logic                 pin;
        pool_result_t         expd;
    } stim_row_t;

    localparam int NUM_DIRECTED = 34;

    localparam stim_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd0,          32'd0,
          1'b1, '{ST_ZERO,      32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'hFFFF_FFFF,  32'd0,
          1'b1, '{ST_LARGE,     32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd17,         32'd0,
          1'b1, '{ST_LARGE,     32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd16,         32'd0,
          1'b1, '{ST_OK,        32'd4096,       9'd1, 9'd255}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd1,          32'd0,
          1'b1, '{ST_OK,        32'd4112,       9'd2, 9'd254}},
        // null free
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'hFFFF_FFFF,  32'd0,
          1'b1, '{ST_OK,        32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4095,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4100,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd8192,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'hFFFF_FFFF,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4096,
          1'b1, '{ST_OK,        32'd0,          9'd1, 9'd255}},
        // double free goes through unnoticed
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4096,
          1'b1, '{ST_OK,        32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4112,
          1'b1, '{ST_NONE_USED, 32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd16,         32'd0,
          1'b1, '{ST_OK,        32'd4096,       9'd1, 9'd255}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd5,          32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_SPARE,   CFG_POOL_BASE,   32'hFFFF_FFFF,  32'hFFFF_FFFF,
          1'b1, '{ST_OK,        32'd0,          9'd2, 9'd254}},
        '{ROW_OP,  MODE_REBUILD, CFG_POOL_BASE,   32'd0,          32'd0,
          1'b1, '{ST_OK,        32'd0,          9'd0, 9'd256}},
        '{ROW_REG, MODE_ALLOC,   CFG_NUM_BLOCKS,  32'd1,          32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd16,         32'd0,
          1'b1, '{ST_OK,        32'd4096,       9'd1, 9'd0}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd16,         32'd0,
          1'b1, '{ST_EXHAUSTED, 32'd0,          9'd1, 9'd0}},
        // empty pool, list not rebuilt by the write
        '{ROW_REG, MODE_ALLOC,   CFG_NUM_BLOCKS,  32'd0,          32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'd4096,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd1, 9'd0}},
        '{ROW_OP,  MODE_REBUILD, CFG_POOL_BASE,   32'd0,          32'd0,
          1'b1, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd1,          32'd0,
          1'b1, '{ST_EXHAUSTED, 32'd0,          9'd0, 9'd0}},
        // zero block size, count above capacity
        '{ROW_REG, MODE_ALLOC,   CFG_BLOCK_SIZE,  32'd0,          32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_REG, MODE_ALLOC,   CFG_NUM_BLOCKS,  32'd300,        32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_REG, MODE_ALLOC,   CFG_POOL_BASE,   32'hFFFF_FF00,  32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd1,          32'd0,
          1'b1, '{ST_LARGE,     32'd0,          9'd0, 9'd256}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'hFFFF_FF00,
          1'b1, '{ST_NOT_OWNED, 32'd0,          9'd0, 9'd256}},
        // widest block at the top of the address space: second block wraps
        '{ROW_REG, MODE_ALLOC,   CFG_BLOCK_SIZE,  32'd65535,      32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_REG, MODE_ALLOC,   CFG_POOL_BASE,   32'hFFFF_FFFF,  32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd65535,      32'd0,
          1'b1, '{ST_OK,        32'hFFFF_FFFF,  9'd1, 9'd255}},
        '{ROW_OP,  MODE_ALLOC,   CFG_POOL_BASE,   32'd1,          32'd0,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}},
        '{ROW_OP,  MODE_FREE,    CFG_POOL_BASE,   32'd0,          32'h0000_FFFE,
          1'b0, '{ST_OK,        32'd0,          9'd0, 9'd0}}
    };

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode         = MODE_ALLOC;
    logic [ADDR_W-1:0]     i_request_size = '0;
    logic [ADDR_W-1:0]     i_free_address = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_POOL_BASE;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_result_valid;
    logic [STAT_W-1:0]     o_status;
    logic [ADDR_W-1:0]     o_block_address;
    logic [CNT_W-1:0]      o_used_blocks;
    logic [CNT_W-1:0]      o_free_blocks;

    // free-list model
    logic [ADDR_W-1:0] cfg_base;
    logic [SIZE_W-1:0] cfg_bsize;
    logic [CNT_W-1:0]  cfg_bcount;
    logic [CNT_W-1:0]  link_mem [0:MAX_SLOTS-1];
    logic [CNT_W-1:0]  head_idx;
    logic [CNT_W-1:0]  used_cnt;

    pool_result_t      pending_results [$];
    logic [ADDR_W-1:0] granted_addrs [$];
    pool_result_t      oldest;

    int ops_issued    = 0;
    int results_done  = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;
    int settings_used = 0;
    int n_grants      = 0;
    int n_exhausted   = 0;
    int n_frees       = 0;

    fixed_block_pool_allocator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_request_size  (i_request_size),
        .i_free_address  (i_free_address),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_used_blocks   (o_used_blocks),
        .o_free_blocks   (o_free_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_count();
        return (int'(cfg_bcount) > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_bcount);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input int idx);
        logic [63:0] sum;
        sum = {32'd0, cfg_base} + 64'(idx) * 64'(cfg_bsize);
        return sum[ADDR_W-1:0];
    endfunction

    function automatic void rebuild_free_list();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            link_mem[i] = CNT_W'(i + 1);
        end
        head_idx = '0;
        used_cnt = '0;
    endfunction

    function automatic pool_result_t predict_pool_op(input logic [MODE_W-1:0] op,
                                                     input logic [ADDR_W-1:0] req,
                                                     input logic [ADDR_W-1:0] faddr);
        pool_result_t r;
        int           cnt;
        logic [63:0]  offs;
        logic [63:0]  idx;
        logic         owned;
        r     = '0;
        cnt   = eff_count();
        offs  = '0;
        owned = 1'b0;
        r.status = ST_OK;
        if (op == MODE_ALLOC) begin
            if (req == '0) begin
                r.status = ST_ZERO;
            end else if (req > {16'd0, cfg_bsize}) begin
                r.status = ST_LARGE;
            end else if (int'(used_cnt) >= cnt || int'(head_idx) >= MAX_SLOTS) begin
                r.status = ST_EXHAUSTED;
            end else begin
                r.addr   = slot_addr(int'(head_idx));
                head_idx = link_mem[head_idx[7:0]];
                used_cnt = used_cnt + CNT_W'(1);
            end
        end else if (op == MODE_FREE && faddr != '0) begin
            if (cfg_bsize != '0 && faddr >= cfg_base) begin
                offs  = {32'd0, faddr - cfg_base};
                owned = (offs < 64'(cfg_bsize) * 64'(cnt)) && (offs % 64'(cfg_bsize) == 0);
            end
            if (!owned) begin
                r.status = ST_NOT_OWNED;
            end else if (used_cnt == '0) begin
                r.status = ST_NONE_USED;
            end else begin
                idx = offs / 64'(cfg_bsize);
                if (idx < 64'(MAX_SLOTS)) begin
                    link_mem[idx[7:0]] = head_idx;
                    head_idx = idx[CNT_W-1:0];
                    used_cnt = used_cnt - CNT_W'(1);
                end else begin
                    r.status = ST_NOT_OWNED;
                end
            end
        end else if (op == MODE_REBUILD) begin
            rebuild_free_list();
        end
        r.used  = used_cnt;
        r.avail = (cnt > int'(used_cnt)) ? CNT_W'(cnt - int'(used_cnt)) : '0;
        return r;
    endfunction

    // Drive one op, hold it until the block takes it, then log the expected beat.
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [ADDR_W-1:0] req,
                           input logic [ADDR_W-1:0] faddr, input logic pin,
                           input pool_result_t pinned);
        pool_result_t pred;
        bit           found;
        start          <= 1'b1;
        i_mode         <= op;
        i_request_size <= req;
        i_free_address <= faddr;
        do @(posedge i_clk); while (busy);
        pred = predict_pool_op(op, req, faddr);
        pending_results.push_back(pin ? pinned : pred);
        ops_issued++;
        if (op == MODE_ALLOC && pred.status == ST_OK) begin
            granted_addrs.push_back(pred.addr);
            n_grants++;
        end else if (op == MODE_ALLOC && pred.status == ST_EXHAUSTED) begin
            n_exhausted++;
        end else if (op == MODE_FREE && pred.status == ST_OK && faddr != '0) begin
            n_frees++;
            found = 1'b0;
            for (int k = 0; k < granted_addrs.size() && !found; k++) begin
                if (granted_addrs[k] == faddr) begin
                    granted_addrs.delete(k);
                    found = 1'b1;
                end
            end
        end else if (op == MODE_REBUILD) begin
            granted_addrs.delete();
        end
    endtask

    // sender holds off until every outstanding beat is back
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (results_done != ops_issued);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_POOL_BASE:   cfg_base   = data;
            CFG_BLOCK_SIZE:  cfg_bsize  = data[SIZE_W-1:0];
            CFG_NUM_BLOCKS:  cfg_bcount = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random_op();
        int                r;
        int                s;
        int                cnt;
        logic [MODE_W-1:0] op;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] fa;
        r   = $urandom_range(0, 99);
        s   = $urandom_range(0, 99);
        cnt = eff_count();
        req = $urandom();
        fa  = $urandom();
        if (r < 46) begin
            op = MODE_ALLOC;
            if (s < 82) begin
                req = $urandom_range(1, (cfg_bsize == '0) ? 1 : int'(cfg_bsize));
            end else if (s < 87) begin
                req = '0;
            end else if (s < 94) begin
                req = {16'd0, cfg_bsize} + $urandom_range(1, 3);
            end
        end else if (r < 92) begin
            op = MODE_FREE;
            if (s < 70 && granted_addrs.size() != 0) begin
                fa = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
            end else if (s < 82) begin
                fa = slot_addr((cnt == 0) ? 0 : $urandom_range(0, cnt - 1));
            end else if (s < 87) begin
                fa = '0;
            end else if (s < 94) begin
                // just off a block boundary, or just below the pool
                fa = (s < 91) ? slot_addr($urandom_range(0, MAX_SLOTS - 1)) + $urandom_range(1, 15)
                              : cfg_base - 1;
            end
        end else if (r < 95) begin
            op = MODE_REBUILD;
        end else begin
            op = MODE_SPARE;
        end
        send_op(op, req, fa, 1'b0, '0);
    endtask

    task automatic run_phase(input int ph);
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] bsz;
        logic [CNT_W-1:0]  cnt;
        logic [31:0]       junk_a;
        logic [31:0]       junk_b;
        int                idle_pct;
        base = $urandom();
        bsz  = SIZE_W'($urandom_range(1, 65535));
        cnt  = CNT_W'($urandom_range(1, 256));
        case (ph)
            0: begin base = 32'd4096; bsz = 16'd16; cnt = 9'd256; end
            1: bsz = SIZE_W'($urandom_range(1, 64));
            2: begin base = 32'd1; bsz = 16'd1; cnt = 9'd256; end
            3: begin base = 32'hFFFF_FFFF; bsz = 16'hFFFF; cnt = 9'd256; end
            4: cnt = CNT_W'($urandom_range(1, 8));
            5: begin bsz = '0; cnt = CNT_W'($urandom_range(0, 511)); end
            6: begin
                base = $urandom_range(1, 1 << 20);
                bsz  = SIZE_W'($urandom_range(1, 300));
                cnt  = CNT_W'($urandom_range(257, 511));
            end
            default: bsz = SIZE_W'($urandom_range(1, 4096));
        endcase
        junk_a = $urandom();
        junk_b = $urandom();
        settle();
        // upper data bits are junk; the block keeps only the register width
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_BLOCK_SIZE, {junk_a[31:SIZE_W], bsz});
        write_reg(CFG_NUM_BLOCKS, {junk_b[31:CNT_W], cnt});
        i_cfg_we <= 1'b0;
        settings_used++;
        // last phase keeps the old list under new registers
        if (ph != N_PHASES - 1) begin
            send_op(MODE_REBUILD, $urandom(), $urandom(), 1'b0, '0);
        end
        idle_pct = (ph < 3) ? 18 : (ph < 6) ? 76 : 0;
        repeat (N_PHASE_OPS) begin
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else if ($urandom_range(0, 299) == 0) begin
                settle();
            end
            send_random_op();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d addr %h",
                       o_status, o_block_address);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (o_status != oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, o_status);
                    fail_count++;
                end
                if (o_block_address != oldest.addr) begin
                    $error("block_address: expected %h, got %h", oldest.addr, o_block_address);
                    fail_count++;
                end
                if (o_used_blocks != oldest.used) begin
                    $error("used_blocks: expected %0d, got %0d", oldest.used, o_used_blocks);
                    fail_count++;
                end
                if (o_free_blocks != oldest.avail) begin
                    $error("free_blocks: expected %0d, got %0d", oldest.avail, o_free_blocks);
                    fail_count++;
                end
            end
            results_done <= results_done + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        cfg_base   = RST_POOL_BASE;
        cfg_bsize  = RST_BLOCK_SIZE;
        cfg_bcount = RST_NUM_BLOCKS;
        rebuild_free_list();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                settle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].word);
                i_cfg_we <= 1'b0;
            end else begin
                send_op(DIRECTED[i].mode, DIRECTED[i].word, DIRECTED[i].faddr,
                        DIRECTED[i].pin, DIRECTED[i].expd);
            end
        end
        settings_used++;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            run_phase(ph);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_results.size());
            fail_count++;
        end

        $display("Ran %0d ops over %0d register settings, %0d result beats checked.",
                 ops_issued, settings_used, results_done);
        $display("Blocks granted %0d, returned %0d, allocations refused as exhausted %0d.",
                 n_grants, n_frees, n_exhausted);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
